// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle check, disabled during reset.
`define ASSERT_NOW(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication check, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/chte_pkg.sv -----
// ----------------------------------------------------------------------------
// chte_pkg
// Shared codes and types for the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int LINK_W = 7;
  localparam int CNT_W  = 7;
  localparam logic [LINK_W-1:0] LINK_NIL = 7'd127;

  localparam logic [2:0] OP_INS   = 3'd0;
  localparam logic [2:0] OP_DEL   = 3'd1;
  localparam logic [2:0] OP_DELID = 3'd2;
  localparam logic [2:0] OP_COL   = 3'd3;
  localparam logic [2:0] OP_MOV   = 3'd4;
  localparam logic [2:0] OP_CLR   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NF   = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] PH_FIND = 2'd0;
  localparam logic [1:0] PH_REM  = 2'd1;
  localparam logic [1:0] PH_INS  = 2'd2;

  typedef struct packed {
    logic [1:0]       status;
    logic [11:0]      year;
    logic [15:0]      id;
    logic [15:0]      tag;
    logic [CNT_W-1:0] count;
    logic             last;
  } res_t;

endpackage

// ----- rtl/chained_hash_table_engine_top.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top
// Fixed-capacity separate-chaining hash table of (year, id, tag) records.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one command word per operation. tuser = op, tdata = year, id,
//   new_year, tag. m_axis: result words; tuser = status, tdata = year, id,
//   tag, count; tlast marks the final word of an operation (collect may give
//   several words, every other op gives one).
//   cfg_we_i/cfg_data_i write num_buckets and empty the table; write only
//   while the engine is idle.
// Timing: one command at a time; s_axis_tready is high only when idle.
//   The bucket index comes from a bit-serial remainder unit. Each chain
//   step is a registered slot memory read followed by a check. Insert
//   scans the used bits one slot per cycle. Delete-by-id walks every
//   bucket. Clear and full-insert go straight to the result state.
// Reset: table empty, num_buckets = 5, no clearing pass needed.
// Stall: a single output register holds a result while m_axis_tready is low;
//   a collect walk pauses until the held word is taken.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_top #(
  parameter int CAPACITY = 64,
  parameter int BUCKETS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // year[11:0], id[27:12], new_year[39:28], tag[55:40]
  input  logic [2:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // year[11:0], id[27:12], tag[43:28], count[50:44]
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast
);
  import chte_pkg::*;
  `include "assert_macros.svh"

  localparam int SW = $clog2(CAPACITY);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [LINK_W-1:0] CAP_L = LINK_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  CAP_C = CNT_W'(CAPACITY);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD  = 4'd1;
  localparam logic [3:0] S_WALK = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_NXB  = 4'd4;
  localparam logic [3:0] S_FREE = 4'd5;
  localparam logic [3:0] S_INSW = 4'd6;
  localparam logic [3:0] S_LINK = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0] state_q, state_d;
  logic [4:0] nb_q, nb_d;
  logic [2:0] op_q, op_d;
  logic [11:0] year_q, year_d, ny_q, ny_d;
  logic [15:0] id_q, id_d, tag_q, tag_d, keep_q, keep_d;
  logic [1:0] phase_q, phase_d;
  logic found_q, found_d;
  logic [BW-1:0] bkt_q, bkt_d;
  logic [LINK_W-1:0] cur_q, cur_d, prev_q, prev_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, fill_q, fill_d;
  logic [4:0] mrem_q, mrem_d;
  logic [11:0] mval_q, mval_d;
  logic [3:0] mbit_q, mbit_d;
  logic [SW-1:0] free_q, free_d;
  logic [CAPACITY-1:0] used_q, used_d;
  logic [LINK_W-1:0] first_q [BUCKETS];
  logic [LINK_W-1:0] first_d [BUCKETS];
  logic [LINK_W-1:0] final_q [BUCKETS];
  logic [LINK_W-1:0] final_d [BUCKETS];
  res_t res_q, res_d, pend_q, pend_d, out_q, out_d;
  logic pend_v_q, pend_v_d, ov_q, ov_d;

  // slot memories, registered read at cur_q
  logic [11:0] year_mem [CAPACITY];
  logic [15:0] id_mem   [CAPACITY];
  logic [15:0] tag_mem  [CAPACITY];
  logic [LINK_W-1:0] next_mem [CAPACITY];
  logic [11:0] rd_year_q;
  logic [15:0] rd_id_q, rd_tag_q;
  logic [LINK_W-1:0] rd_next_q;
  logic mem_we, nx_we;
  logic [SW-1:0] nx_addr;
  logic [LINK_W-1:0] nx_data;

  logic [4:0] eff;
  logic [5:0] mod_t;
  logic [4:0] mod_r;
  logic out_free, id_eq, year_eq, is_rem, bkt_more;
  res_t ok_res;

  always_comb begin
    if (nb_q == 5'd0) eff = 5'd1;
    else if (int'(nb_q) > BUCKETS) eff = 5'(BUCKETS);
    else eff = nb_q;
  end

  // one remainder step: shift in next year bit, subtract modulus if it fits
  always_comb begin
    mod_t = {mrem_q, mval_q[11]};
    if (mod_t >= {1'b0, eff}) mod_t = mod_t - {1'b0, eff};
    mod_r = mod_t[4:0];
  end

  assign out_free = !ov_q || m_axis_tready;
  assign id_eq    = (rd_id_q == id_q);
  assign year_eq  = (rd_year_q == year_q);
  assign is_rem   = (op_q == OP_DEL) || (op_q == OP_DELID) ||
                    ((op_q == OP_MOV) && (phase_q == PH_REM));
  assign bkt_more = ((9'(bkt_q) + 9'd1) < 9'(eff));
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    ok_res = '0;
    ok_res.status = ST_OK;
    ok_res.last = 1'b1;
  end

  always_comb begin
    state_d = state_q; nb_d = nb_q; op_d = op_q; year_d = year_q; ny_d = ny_q;
    id_d = id_q; tag_d = tag_q; keep_d = keep_q; phase_d = phase_q;
    found_d = found_q; bkt_d = bkt_q; cur_d = cur_q; prev_d = prev_q;
    cnt_d = cnt_q; fill_d = fill_q; mrem_d = mrem_q; mval_d = mval_q;
    mbit_d = mbit_q; free_d = free_q; used_d = used_q;
    first_d = first_q; final_d = final_q;
    res_d = res_q; pend_d = pend_q; pend_v_d = pend_v_q;
    out_d = out_q; ov_d = ov_q;
    mem_we = 1'b0; nx_we = 1'b0; nx_addr = '0; nx_data = '0;

    if (m_axis_tready) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d = s_axis_tuser;
          year_d = s_axis_tdata[11:0];
          id_d = s_axis_tdata[27:12];
          ny_d = s_axis_tdata[39:28];
          tag_d = s_axis_tdata[55:40];
          cnt_d = '0; found_d = 1'b0; phase_d = PH_FIND; pend_v_d = 1'b0;
          mval_d = s_axis_tdata[11:0]; mrem_d = '0; mbit_d = 4'd11;
          res_d = '0; res_d.last = 1'b1;
          unique case (s_axis_tuser)
            OP_INS: begin
              if (fill_q == CAP_C) begin
                res_d.status = ST_FULL;
                state_d = S_EMIT;
              end else begin
                state_d = S_MOD;
              end
            end
            OP_DEL, OP_COL, OP_MOV: state_d = S_MOD;
            OP_DELID: begin
              bkt_d = '0;
              cur_d = first_q[0];
              prev_d = LINK_NIL;
              state_d = S_WALK;
            end
            OP_CLR: begin
              res_d.status = ST_OK;
              res_d.count = fill_q;
              used_d = '0; fill_d = '0;
              for (int i = 0; i < BUCKETS; i++) begin
                first_d[i] = LINK_NIL;
                final_d[i] = LINK_NIL;
              end
              state_d = S_EMIT;
            end
            default: begin
              res_d.status = ST_NF;
              state_d = S_EMIT;
            end
          endcase
        end
        if (cfg_we_i) begin
          nb_d = cfg_data_i;
          used_d = '0; fill_d = '0;
          for (int i = 0; i < BUCKETS; i++) begin
            first_d[i] = LINK_NIL;
            final_d[i] = LINK_NIL;
          end
        end
      end

      S_MOD: begin
        mrem_d = mod_r;
        mval_d = {mval_q[10:0], 1'b0};
        mbit_d = mbit_q - 4'd1;
        if (mbit_q == 4'd0) begin
          bkt_d = BW'(mod_r);
          if ((op_q == OP_INS) || ((op_q == OP_MOV) && (phase_q == PH_INS))) begin
            free_d = '0;
            state_d = S_FREE;
          end else begin
            cur_d = first_q[BW'(mod_r)];
            prev_d = LINK_NIL;
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (cur_q >= CAP_L) begin
          // end of chain
          if (op_q == OP_DELID) begin
            state_d = S_NXB;
          end else if (op_q == OP_COL) begin
            if (pend_v_q) begin
              res_d = pend_q;
              res_d.last = 1'b1;
            end else begin
              res_d.status = ST_NF;
            end
            state_d = S_EMIT;
          end else if ((op_q == OP_MOV) && (phase_q == PH_FIND) && found_q) begin
            phase_d = PH_REM;
            cur_d = first_q[bkt_q];
            prev_d = LINK_NIL;
          end else begin
            res_d.status = ST_NF;
            state_d = S_EMIT;
          end
        end else begin
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        state_d = S_WALK;
        prev_d = cur_q;
        cur_d = rd_next_q;
        if (is_rem && id_eq && ((op_q == OP_DELID) || year_eq)) begin
          if (prev_q >= CAP_L) begin
            first_d[bkt_q] = rd_next_q;
          end else begin
            nx_we = 1'b1;
            nx_addr = prev_q[SW-1:0];
            nx_data = rd_next_q;
          end
          if (final_q[bkt_q] == cur_q) final_d[bkt_q] = prev_q;
          used_d[cur_q[SW-1:0]] = 1'b0;
          fill_d = fill_q - CNT_W'(1);
          if (op_q == OP_DEL) begin
            res_d = ok_res;
            res_d.count = CNT_W'(1);
            state_d = S_EMIT;
          end else if (op_q == OP_DELID) begin
            cnt_d = cnt_q + CNT_W'(1);
            state_d = S_NXB;
          end else begin
            // move: re-insert under the new year with the kept tag
            phase_d = PH_INS;
            year_d = ny_q;
            tag_d = keep_q;
            mval_d = ny_q; mrem_d = '0; mbit_d = 4'd11;
            state_d = S_MOD;
          end
        end else if ((op_q == OP_MOV) && (phase_q == PH_FIND)) begin
          if (id_eq && year_eq) begin
            found_d = 1'b1;
            keep_d = rd_tag_q;
          end
        end else if ((op_q == OP_COL) && year_eq) begin
          if (pend_v_q && !out_free) begin
            // hold position until the output register frees
            state_d = S_CHK;
            prev_d = prev_q;
            cur_d = cur_q;
          end else begin
            if (pend_v_q) begin
              out_d = pend_q;
              ov_d = 1'b1;
            end
            pend_v_d = 1'b1;
            pend_d = '0;
            pend_d.status = ST_OK;
            pend_d.year = rd_year_q;
            pend_d.id = rd_id_q;
            pend_d.tag = rd_tag_q;
            pend_d.count = cnt_q;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end

      S_NXB: begin
        if (bkt_more) begin
          bkt_d = bkt_q + BW'(1);
          cur_d = first_q[bkt_q + BW'(1)];
          prev_d = LINK_NIL;
          state_d = S_WALK;
        end else begin
          res_d = ok_res;
          res_d.status = (cnt_q == '0) ? ST_NF : ST_OK;
          res_d.count = cnt_q;
          state_d = S_EMIT;
        end
      end

      S_FREE: begin
        if (!used_q[free_q]) state_d = S_INSW;
        else free_d = free_q + SW'(1);
      end

      S_INSW: begin
        mem_we = 1'b1;
        used_d[free_q] = 1'b1;
        fill_d = fill_q + CNT_W'(1);
        res_d = ok_res;
        res_d.count = (op_q == OP_MOV) ? CNT_W'(1) : CNT_W'(0);
        if ((first_q[bkt_q] >= CAP_L) || (final_q[bkt_q] >= CAP_L)) begin
          first_d[bkt_q] = LINK_W'(free_q);
          final_d[bkt_q] = LINK_W'(free_q);
          state_d = S_EMIT;
        end else begin
          state_d = S_LINK;
        end
      end

      S_LINK: begin
        nx_we = 1'b1;
        nx_addr = final_q[bkt_q][SW-1:0];
        nx_data = LINK_W'(free_q);
        final_d[bkt_q] = LINK_W'(free_q);
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_d = res_q;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      year_mem[free_q] <= year_q;
      id_mem[free_q] <= id_q;
      tag_mem[free_q] <= tag_q;
    end
    if (mem_we) next_mem[free_q] <= LINK_NIL;
    else if (nx_we) next_mem[nx_addr] <= nx_data;
    rd_year_q <= year_mem[cur_q[SW-1:0]];
    rd_id_q <= id_mem[cur_q[SW-1:0]];
    rd_tag_q <= tag_mem[cur_q[SW-1:0]];
    rd_next_q <= next_mem[cur_q[SW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nb_q <= 5'd5;
      used_q <= '0;
      fill_q <= '0;
      ov_q <= 1'b0;
      pend_v_q <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        first_q[i] <= LINK_NIL;
        final_q[i] <= LINK_NIL;
      end
    end else begin
      state_q <= state_d;
      nb_q <= nb_d;
      used_q <= used_d;
      fill_q <= fill_d;
      ov_q <= ov_d;
      pend_v_q <= pend_v_d;
      first_q <= first_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; year_q <= year_d; ny_q <= ny_d; id_q <= id_d; tag_q <= tag_d;
    keep_q <= keep_d; phase_q <= phase_d; found_q <= found_d; bkt_q <= bkt_d;
    cur_q <= cur_d; prev_q <= prev_d; cnt_q <= cnt_d; mrem_q <= mrem_d;
    mval_q <= mval_d; mbit_q <= mbit_d; free_q <= free_d;
    res_q <= res_d; pend_q <= pend_d; out_q <= out_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {5'd0, out_q.count, out_q.tag, out_q.id, out_q.year};

  `ASSERT_NOW(a_fill_cap, clk_i, rst_ni, fill_q <= CAP_C, "fill count above capacity")
  `ASSERT_NOW(a_chk_valid, clk_i, rst_ni, (state_q != S_CHK) || (cur_q < CAP_L),
              "chain check on null link")
  `ASSERT_IMPL(a_clear, clk_i, rst_ni,
               (state_q == S_IDLE) && s_axis_tvalid && (s_axis_tuser == OP_CLR),
               (used_q == '0) && (fill_q == '0), "clear left records behind")
endmodule
